// ----- src/lifn_pkg.sv -----
// Shared types, constants and codes for the LIF neuron block.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package lifn_pkg;

  localparam int DATA_W    = 32;  // potential, current, levels (Q16.16)
  localparam int FRAC_BITS = 16;  // fraction bits of the Q16.16 values
  localparam int COEF_BITS = 16;  // fraction bits of coefficients (Q1.16 and up)
  localparam int TICK_BITS = 16;  // tick_count width, squaring steps
  localparam int MODE_W    = 2;
  localparam int RES_W     = 31;  // input_resistance
  localparam int SOT_W     = 17;  // step_over_tau
  localparam int DEC_W     = 17;  // decay_per_tick
  localparam int FB_W      = 32;  // power-loop factor and base, clamped
  localparam int MUL_W     = 33;  // shared multiplier operand width
  localparam int PROD_W    = 2 * MUL_W;
  localparam int RND_W     = PROD_W - COEF_BITS;  // rounded product width
  localparam int CFG_IDX_W = 3;

  // item modes
  localparam logic [MODE_W-1:0] MODE_INTEGRATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LEAK      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LONG_LEAK = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FIRE      = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REST_LEVEL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AFTER_FIRE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRE_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_RES      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_OVER_TAU  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_PER_TICK = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PASSTHRU_MODE  = 3'd6;

  localparam logic signed [DATA_W-1:0] ONE_Q     = 1 << FRAC_BITS;
  localparam logic [FB_W-1:0]          COEF_ONE  = 1 << COEF_BITS;
  localparam logic [RES_W-1:0]         RES_RST   = 31'd65536;
  localparam logic [SOT_W-1:0]         SOT_RST   = 17'd6554;
  localparam logic [DEC_W-1:0]         DECAY_RST = 17'd59299;

  typedef struct packed {
    logic signed [DATA_W-1:0] rest_level;
    logic signed [DATA_W-1:0] after_fire_level;
    logic signed [DATA_W-1:0] fire_threshold;
    logic [RES_W-1:0]         input_resistance;
    logic [SOT_W-1:0]         step_over_tau;
    logic [DEC_W-1:0]         decay_per_tick;
    logic                     passthru_mode;
  } cfg_t;

  // where a product is written back, in the cycle after issue
  typedef enum logic [2:0] {
    DST_NONE,
    DST_F,     // power-loop factor
    DST_B,     // power-loop base
    DST_RND,   // rounded magnitude register
    DST_LO,    // accumulator load
    DST_HI     // accumulator add, shifted by MUL_W
  } dst_t;

  typedef struct packed {
    dst_t             dest;
    logic [MUL_W-1:0] op_a;
    logic [MUL_W-1:0] op_b;
  } mul_req_t;

  typedef struct packed {
    dst_t              dest;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

endpackage

// ----- src/lifn_cmd_if.sv -----
// Input item channel of the LIF neuron: valid/ready plus item fields.
// Depends on lifn_pkg for field widths.
`timescale 1ns / 1ps

interface lifn_cmd_if;
  logic                               valid;
  logic                               ready;
  logic [lifn_pkg::MODE_W-1:0]        mode;
  logic signed [lifn_pkg::DATA_W-1:0] spike_in;
  logic [lifn_pkg::TICK_BITS-1:0]     tick_count;

  modport source (output valid, mode, spike_in, tick_count, input ready);
  modport sink (input valid, mode, spike_in, tick_count, output ready);
endinterface

// ----- src/lifn_res_if.sv -----
// Result item channel of the LIF neuron: valid/ready plus result fields.
// Depends on lifn_pkg for field widths.
`timescale 1ns / 1ps

interface lifn_res_if;
  logic                               valid;
  logic                               ready;
  logic                               fired;
  logic signed [lifn_pkg::DATA_W-1:0] intensity;
  logic signed [lifn_pkg::DATA_W-1:0] potential_now;

  modport source (output valid, fired, intensity, potential_now, input ready);
  modport sink (input valid, fired, intensity, potential_now, output ready);
endinterface

// ----- src/lifn_cfg.sv -----
// Configuration register file of the LIF neuron, written by index.
// Depends on lifn_pkg (cfg_t, register indexes, reset values).
`timescale 1ns / 1ps

module lifn_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lifn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lifn_pkg::DATA_W-1:0]       cfg_data,
  output lifn_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rest_level       <= '0;
      cfg.after_fire_level <= '0;
      cfg.fire_threshold   <= lifn_pkg::ONE_Q;
      cfg.input_resistance <= lifn_pkg::RES_RST;
      cfg.step_over_tau    <= lifn_pkg::SOT_RST;
      cfg.decay_per_tick   <= lifn_pkg::DECAY_RST;
      cfg.passthru_mode    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lifn_pkg::REG_REST_LEVEL:     cfg.rest_level       <= cfg_data;
        lifn_pkg::REG_AFTER_FIRE:     cfg.after_fire_level <= cfg_data;
        lifn_pkg::REG_FIRE_THRESHOLD: cfg.fire_threshold   <= cfg_data;
        lifn_pkg::REG_INPUT_RES:
          cfg.input_resistance <= cfg_data[lifn_pkg::RES_W-1:0];
        lifn_pkg::REG_STEP_OVER_TAU:
          cfg.step_over_tau <= cfg_data[lifn_pkg::SOT_W-1:0];
        lifn_pkg::REG_DECAY_PER_TICK:
          cfg.decay_per_tick <= cfg_data[lifn_pkg::DEC_W-1:0];
        lifn_pkg::REG_PASSTHRU_MODE:  cfg.passthru_mode <= cfg_data[0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

endmodule

// ----- src/lifn_mul.sv -----
// Shared 33x33 unsigned multiplier with registered product and write-back tag.
// Depends on lifn_pkg (mul_req_t, mul_rsp_t).
`timescale 1ns / 1ps

module lifn_mul (
  input  logic               clk,
  input  logic               rst,
  input  lifn_pkg::mul_req_t req,
  output lifn_pkg::mul_rsp_t rsp
);

  localparam int PW = lifn_pkg::PROD_W;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.dest <= lifn_pkg::DST_NONE;
    end else begin
      rsp.dest <= req.dest;
    end
    rsp.prod <= PW'(req.op_a) * PW'(req.op_b);
  end

endmodule

// ----- src/lifn_core.sv -----
// Sequencer and datapath of the LIF neuron: neuron state, power loop,
// product write-back, output register. Depends on lifn_pkg, both channel
// interfaces and the shared multiplier in lifn_mul.
`timescale 1ns / 1ps

module lifn_core (
  input  logic               clk,
  input  logic               rst,
  input  lifn_pkg::cfg_t     cfg,
  lifn_cmd_if.sink           cmd,
  lifn_res_if.source         res,
  output lifn_pkg::mul_req_t mreq,
  input  lifn_pkg::mul_rsp_t mrsp
);

  localparam int DW = lifn_pkg::DATA_W;
  localparam int MW = lifn_pkg::MUL_W;
  localparam int PW = lifn_pkg::PROD_W;
  localparam int RW = lifn_pkg::RND_W;
  localparam int SW = RW + 2;  // signed sums around a rounded product
  localparam int CW = lifn_pkg::COEF_BITS;
  localparam int FW = lifn_pkg::FB_W;
  localparam int TB = lifn_pkg::TICK_BITS;
  localparam logic [PW-1:0] HALF = PW'(1) << (CW - 1);

  typedef enum logic [4:0] {
    S_IDLE,
    S_E_MUL1, S_E_WB1, S_E_DRV, S_E_ABS, S_E_MLO, S_E_MHI, S_E_WB2, S_E_RND,
    S_E_APPLY,
    S_L_POW, S_L_SQ, S_L_BW, S_L_MUL, S_L_WB, S_L_APPLY,
    S_OUT
  } state_t;

  state_t                 state;
  logic signed [DW-1:0]   v;        // membrane potential
  logic signed [DW-1:0]   cur;      // input current
  logic                   act;      // activated flag
  logic signed [DW:0]     dif;      // rest - v for Euler drive
  logic [RW-1:0]          dmag;     // multiplicand magnitude
  logic                   neg;      // sign of the pending product
  logic [RW-1:0]          rmag;     // rounded product magnitude
  logic signed [SW-1:0]   drv;      // Euler drive
  logic [PW-1:0]          acc;
  logic [FW-1:0]          fac;
  logic [FW-1:0]          base;
  logic [TB-1:0]          t;        // remaining tick bits, low bit next
  logic                   fired_r;
  logic signed [DW-1:0]   inten_r;

  logic signed [DW:0]     cur_x, v_x, rest_x, vr_diff, rv_diff;
  logic [DW:0]            cur_mag;
  logic                   v_lt_rest;
  logic                   v_gt_thr;
  logic [RW-1:0]          prod_rnd;
  logic [FW-1:0]          prod_clamp;

  function automatic logic signed [DW-1:0] sat_w(input logic signed [SW-1:0] x);
    if (x[SW-1:DW-1] == '0 || x[SW-1:DW-1] == '1) begin
      return x[DW-1:0];
    end else if (x[SW-1]) begin
      return {1'b1, {(DW-1){1'b0}}};
    end else begin
      return {1'b0, {(DW-1){1'b1}}};
    end
  endfunction

  // round to nearest, half up on the magnitude, drop CW fraction bits
  function automatic logic [RW-1:0] round_q(input logic [PW-1:0] p);
    logic [PW-1:0] s;
    s = p + HALF;
    return s[PW-1:CW];
  endfunction

  assign cur_x     = (DW+1)'(cur);
  assign v_x       = (DW+1)'(v);
  assign rest_x    = (DW+1)'(cfg.rest_level);
  assign cur_mag   = cur[DW-1] ? $unsigned(-cur_x) : $unsigned(cur_x);
  assign vr_diff   = v_x - rest_x;
  assign rv_diff   = rest_x - v_x;
  assign v_lt_rest = (v < cfg.rest_level);
  assign v_gt_thr  = (v > cfg.fire_threshold);

  assign prod_rnd   = round_q(mrsp.prod);
  assign prod_clamp = (prod_rnd[RW-1:FW] != '0) ? '1 : prod_rnd[FW-1:0];

  assign cmd.ready = (state == S_IDLE);

  // operand select for the shared multiplier
  always_comb begin
    mreq.dest = lifn_pkg::DST_NONE;
    mreq.op_a = '0;
    mreq.op_b = '0;
    unique case (state)
      S_E_MUL1: begin
        mreq.dest = lifn_pkg::DST_RND;
        mreq.op_a = dmag[MW-1:0];
        mreq.op_b = MW'(cfg.input_resistance);
      end
      S_E_MLO: begin
        mreq.dest = lifn_pkg::DST_LO;
        mreq.op_a = dmag[MW-1:0];
        mreq.op_b = MW'(cfg.step_over_tau);
      end
      S_E_MHI: begin
        mreq.dest = lifn_pkg::DST_HI;
        mreq.op_a = MW'(dmag[RW-1:MW]);
        mreq.op_b = MW'(cfg.step_over_tau);
      end
      S_L_POW: begin
        if (t != '0 && t[0]) begin
          mreq.dest = lifn_pkg::DST_F;
          mreq.op_a = MW'(fac);
          mreq.op_b = MW'(base);
        end else if (t != '0) begin
          mreq.dest = lifn_pkg::DST_B;
          mreq.op_a = MW'(base);
          mreq.op_b = MW'(base);
        end
      end
      S_L_SQ: begin
        if (t[TB-1:1] != '0) begin
          mreq.dest = lifn_pkg::DST_B;
          mreq.op_a = MW'(base);
          mreq.op_b = MW'(base);
        end
      end
      S_L_MUL: begin
        mreq.dest = lifn_pkg::DST_RND;
        mreq.op_a = dmag[MW-1:0];
        mreq.op_b = MW'(fac);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      v         <= '0;
      cur       <= '0;
      act       <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      // S_OUT reloads the register itself when the old item leaves
      if (res.valid && res.ready && state != S_OUT) begin
        res.valid <= 1'b0;
      end

      // product write-back, in the cycle after issue
      unique case (mrsp.dest)
        lifn_pkg::DST_F:   fac  <= prod_clamp;
        lifn_pkg::DST_B:   base <= prod_clamp;
        lifn_pkg::DST_RND: rmag <= prod_rnd;
        lifn_pkg::DST_LO:  acc  <= mrsp.prod;
        lifn_pkg::DST_HI:  acc  <= acc + {mrsp.prod[PW-MW-1:0], {MW{1'b0}}};
        default: ;
      endcase

      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            unique case (cmd.mode)
              lifn_pkg::MODE_INTEGRATE: begin
                cur     <= sat_w(SW'(cur) + SW'(cmd.spike_in));
                act     <= 1'b1;
                fired_r <= 1'b0;
                inten_r <= '0;
                state   <= S_OUT;
              end
              lifn_pkg::MODE_LEAK: begin
                dif     <= rv_diff;
                dmag    <= RW'(cur_mag);
                neg     <= cur[DW-1];
                fired_r <= 1'b0;
                inten_r <= '0;
                state   <= S_E_MUL1;
              end
              lifn_pkg::MODE_LONG_LEAK: begin
                fac     <= lifn_pkg::COEF_ONE;
                base    <= FW'(cfg.decay_per_tick);
                t       <= cmd.tick_count;
                dmag    <= RW'($unsigned(v_lt_rest ? rv_diff : vr_diff));
                neg     <= v_lt_rest;
                fired_r <= 1'b0;
                inten_r <= '0;
                state   <= S_L_POW;
              end
              lifn_pkg::MODE_FIRE: begin
                cur <= '0;
                if (cfg.passthru_mode) begin
                  fired_r <= act;
                  inten_r <= v;
                  act     <= 1'b0;
                  v       <= cfg.after_fire_level;
                end else begin
                  fired_r <= v_gt_thr;
                  inten_r <= lifn_pkg::ONE_Q;
                  if (v_gt_thr) begin
                    v <= cfg.after_fire_level;
                  end
                end
                state <= S_OUT;
              end
              default: ;
            endcase
          end
        end

        // Euler step
        S_E_MUL1: state <= S_E_WB1;
        S_E_WB1:  state <= S_E_DRV;
        S_E_DRV: begin
          drv   <= neg ? SW'(dif) - SW'(rmag) : SW'(dif) + SW'(rmag);
          state <= S_E_ABS;
        end
        S_E_ABS: begin
          neg   <= drv[SW-1];
          dmag  <= RW'(drv[SW-1] ? -drv : drv);
          state <= S_E_MLO;
        end
        S_E_MLO: state <= S_E_MHI;
        S_E_MHI: state <= S_E_WB2;
        S_E_WB2: state <= S_E_RND;
        S_E_RND: begin
          rmag  <= round_q(acc);
          state <= S_E_APPLY;
        end
        S_E_APPLY: begin
          v     <= sat_w(neg ? SW'(v) - SW'(rmag) : SW'(v) + SW'(rmag));
          state <= S_OUT;
        end

        // long leak: decay^ticks, low tick bit first
        S_L_POW: begin
          if (t == '0) begin
            state <= S_L_MUL;
          end else if (t[0]) begin
            state <= S_L_SQ;
          end else begin
            t     <= t >> 1;
            state <= S_L_BW;
          end
        end
        S_L_SQ: begin
          t <= t >> 1;
          if (t[TB-1:1] == '0) begin
            state <= S_L_MUL;
          end else begin
            state <= S_L_BW;
          end
        end
        S_L_BW:  state <= S_L_POW;
        S_L_MUL: state <= S_L_WB;
        S_L_WB:  state <= S_L_APPLY;
        S_L_APPLY: begin
          v <= sat_w(neg ? SW'(cfg.rest_level) - SW'(rmag)
                         : SW'(cfg.rest_level) + SW'(rmag));
          state <= S_OUT;
        end

        S_OUT: begin
          if (!res.valid || res.ready) begin
            res.valid         <= 1'b1;
            res.fired         <= fired_r;
            res.intensity     <= inten_r;
            res.potential_now <= v;
            state             <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_f_wb: assert property (@(posedge clk) disable iff (rst)
    mrsp.dest == lifn_pkg::DST_F |-> state == S_L_SQ)
    else $error("factor write-back outside squaring step");

  a_b_wb: assert property (@(posedge clk) disable iff (rst)
    mrsp.dest == lifn_pkg::DST_B |-> state == S_L_BW)
    else $error("base write-back outside its slot");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> mrsp.dest == lifn_pkg::DST_NONE)
    else $error("product still in flight while idle");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state) == S_OUT)
    else $error("result raised outside output step");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !cmd.ready)
    else $error("second item taken while busy");
`endif

endmodule

// ----- src/lif_neuron_passthru.sv -----
// LIF neuron (Q16.16) top level; uses lifn_pkg, lifn_cmd_if, lifn_res_if,
// lifn_cfg, lifn_mul and lifn_core. One item at a time; the result goes to the
// output register once the item's mode sequence is done and the register is free;
// the long-leak sequence runs longer with each bit of tick_count below its top set bit.
// Next item taken in the cycle after the result is registered. The 33x33 multiplier
// is the shared unit; the power loop sets the long-leak time. Sync reset, active high.
`timescale 1ns / 1ps

module lif_neuron_passthru (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lifn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lifn_pkg::DATA_W-1:0]    cfg_data,
  lifn_cmd_if.sink                       cmd,
  lifn_res_if.source                     res
);

  // Structure:
  //   lifn_cfg  - seven config registers, reset to their defaults.
  //   lifn_mul  - the one multiplier; operands come in with a destination
  //               tag, the product and tag are registered together.
  //   lifn_core - sequencer, neuron state (potential, current, activated),
  //               product write-back and the output register.
  //
  // Modes:
  //   integrate - saturating add of the spike input into the current, done in
  //               the accepting cycle.
  //   Euler     - |I|*R rounded, drive = rest - V +/- that, then |drive|*dt/tau
  //               in two partial products (low 33 bits, high bits shifted by
  //               33), rounded, added to V with saturation.
  //   long leak - decay^ticks by right-to-left squaring; products rounded and
  //               clamped to 32 bits; the square after the top tick bit is
  //               skipped. Then V = rest +/- round(|V - rest| * factor).
  //   fire      - passthru reports the activated flag and the potential;
  //               threshold mode compares V against the threshold. Done in
  //               the accepting cycle.
  //
  // All roundings are half away from zero: the magnitude is rounded and the
  // sign applied afterwards.
  //
  // The output register decouples the result side: a finished result waits
  // there while the block goes back to idle and takes the next item.

  lifn_pkg::cfg_t     cfg;
  lifn_pkg::mul_req_t mreq;
  lifn_pkg::mul_rsp_t mrsp;

  lifn_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lifn_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  lifn_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .cmd  (cmd),
    .res  (res),
    .mreq (mreq),
    .mrsp (mrsp)
  );

endmodule
